### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked during reset too
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bmcs_pkg.sv
// Types and constants of the bus master command sequencer.
package bmcs_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int LOG_DEPTH    = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LIDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LCNT_W = $clog2(LOG_DEPTH + 1);
  localparam int ENTRY_W = 5 + PAYLOAD_BITS;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ADDR_SEL_BIT = 2;

  localparam logic REG_TIMEOUT_LIMIT = 1'b0;
  localparam logic REG_TIMEOUT_CODE  = 1'b1;

  localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd500;
  localparam logic [7:0]  TIMEOUT_CODE_RST  = 8'd1;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POLL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_OK      = 2'd1,
    ST_FAIL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_REINIT  = 3'd0,
    PH_FETCH   = 3'd1,
    PH_EXEC    = 3'd2,
    PH_TIMEOUT = 3'd3,
    PH_SAVE    = 3'd4,
    PH_FINISH  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_DATA
  } ctl_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [4:0]              command_function;
    logic [PAYLOAD_BITS-1:0] command_payload;
    logic [1:0]              exec_status;
    logic [7:0]              error_number;
    logic [3:0]              log_index;
  } cmd_t;

  typedef struct packed {
    logic                    step_done;
    logic [2:0]              phase;
    logic [4:0]              active_function;
    logic [PAYLOAD_BITS-1:0] active_payload;
    logic [1:0]              link_status;
    logic [4:0]              error_count;
    logic [7:0]              log_entry;
    logic                    queue_empty;
  } rsp_t;

  typedef struct packed {
    logic [4:0]              func;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

endpackage

### hdl/bmcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bus_master_command_sequencer.sv
// Top level of the bus master command sequencer: command ring, sequencer, error log.
//
//  channel | dir | handshake               | beat
//  cmd     | in  | cmd_valid / cmd_stall   | cmd_t: push, tick or poll
//  rsp     | out | rsp_valid / rsp_stall   | rsp_t: state after the item
//  apb     | in  | psel/penable/pready     | timeout_limit @0, timeout_code @4
//
// An item runs in order: the accept edge updates pointers and writes the command
// and log RAMs, the CTL_READ cycle reads both RAMs (active slot, log index), and
// CTL_DATA loads the result register once no stalled result is held. The registered
// RAM read, issued only after the accept-edge write has landed, sets this order.
// Reset clears 16 store valid bits at once; no clearing pass.
// A stalled result holds; the next item is accepted while it waits.
module bus_master_command_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  bmcs_pkg::cmd_t                   cmd,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output bmcs_pkg::rsp_t                   rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bmcs_pkg::PADDR_W-1:0]     paddr,
  input  logic [bmcs_pkg::PDATA_W-1:0]     pwdata,
  output logic [bmcs_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import bmcs_pkg::*;

  ctl_t              ctl, ctl_next;
  logic [QPTR_W-1:0] wp, wp_next;
  logic [QPTR_W-1:0] rp, rp_next;
  logic [QPTR_W-1:0] act, act_next;
  phase_t            phase, phase_next;
  logic [15:0]       tick, tick_next;
  logic [LCNT_W-1:0] lcnt, lcnt_next;
  status_t           status, status_next;
  logic [QUEUE_DEPTH-1:0] qvalid, qvalid_next;
  logic              done, done_next;
  logic [3:0]        idx;
  logic [15:0]       timeout_limit;
  logic [7:0]        timeout_code;

  logic              accept;
  logic              store_we;
  entry_t            store_wdata;
  entry_t            store_rdata;
  logic              log_we;
  logic [7:0]        log_wdata;
  logic [7:0]        log_rdata;
  logic              load_rsp;
  status_t           poll_status;
  rsp_t              rsp_next;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (ctl != CTL_IDLE);
  assign pready    = 1'b1;
  assign load_rsp  = (ctl == CTL_DATA) && (!rsp_valid || !rsp_stall);

  assign store_wdata.func    = cmd.command_function;
  assign store_wdata.payload = cmd.command_payload;

  bmcs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp),
    .wdata (store_wdata),
    .raddr (act),
    .rdata (store_rdata)
  );

  bmcs_ram #(.WIDTH(8), .DEPTH(LOG_DEPTH)) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (LIDX_W'(lcnt)),
    .wdata (log_wdata),
    .raddr (LIDX_W'(idx)),
    .rdata (log_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_LIMIT_RST;
      timeout_code  <= TIMEOUT_CODE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[ADDR_SEL_BIT] == REG_TIMEOUT_LIMIT) begin
        timeout_limit <= pwdata[15:0];
      end else begin
        timeout_code <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[ADDR_SEL_BIT] == REG_TIMEOUT_CODE) ?
                  {{(PDATA_W-8){1'b0}}, timeout_code} :
                  {{(PDATA_W-16){1'b0}}, timeout_limit};

  assign poll_status = (cmd.exec_status == ST_OK)   ? ST_OK :
                       (cmd.exec_status == ST_FAIL) ? ST_FAIL : ST_PENDING;

  always_comb begin
    wp_next     = wp;
    rp_next     = rp;
    act_next    = act;
    phase_next  = phase;
    tick_next   = tick;
    lcnt_next   = lcnt;
    status_next = status;
    qvalid_next = qvalid;
    done_next   = done;
    store_we    = 1'b0;
    log_we      = 1'b0;
    log_wdata   = cmd.error_number;
    if (accept) begin
      done_next = 1'b0;
      case (cmd.kind)
        KIND_PUSH: begin
          store_we        = 1'b1;
          qvalid_next[wp] = 1'b1;
          wp_next = (int'(wp) == QUEUE_DEPTH - 1) ? '0 : wp + 1'b1;
        end
        KIND_TICK: begin
          if (tick != '1) begin
            tick_next = tick + 16'd1;
          end
        end
        KIND_POLL: begin
          case (phase)
            PH_REINIT: begin
              qvalid_next = '0;
              wp_next     = '0;
              rp_next     = '0;
              lcnt_next   = '0;
              phase_next  = PH_FETCH;
              tick_next   = '0;
            end
            PH_FETCH: begin
              if (rp != wp) begin
                act_next   = rp;
                rp_next    = (int'(rp) == QUEUE_DEPTH - 1) ? '0 : rp + 1'b1;
                phase_next = PH_EXEC;
              end
              tick_next = '0;
            end
            PH_EXEC: begin
              status_next = poll_status;
              if (poll_status == ST_OK) begin
                phase_next = PH_FINISH;
              end
              if (poll_status == ST_FAIL) begin
                phase_next = PH_SAVE;
              end
              if (tick > timeout_limit) begin
                phase_next = PH_TIMEOUT;
              end
            end
            PH_TIMEOUT: begin
              status_next = ST_FAIL;
              log_wdata   = timeout_code;
              if (int'(lcnt) < LOG_DEPTH) begin
                log_we    = 1'b1;
                lcnt_next = lcnt + 1'b1;
              end
              phase_next = PH_REINIT;
            end
            PH_SAVE: begin
              if (int'(lcnt) < LOG_DEPTH) begin
                log_we    = 1'b1;
                lcnt_next = lcnt + 1'b1;
              end
              phase_next = PH_FETCH;
              done_next  = 1'b1;
            end
            PH_FINISH: begin
              phase_next = PH_FETCH;
              done_next  = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl_next = ctl;
    case (ctl)
      CTL_IDLE: if (accept) ctl_next = CTL_READ;
      CTL_READ: ctl_next = CTL_DATA;
      CTL_DATA: if (load_rsp) ctl_next = CTL_IDLE;
      default:  ctl_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    rsp_next.step_done       = done;
    rsp_next.phase           = phase;
    rsp_next.active_function = qvalid[act] ? store_rdata.func : '0;
    rsp_next.active_payload  = qvalid[act] ? store_rdata.payload : '0;
    rsp_next.link_status     = status;
    rsp_next.error_count     = 5'(lcnt);
    rsp_next.log_entry       = (int'(idx) < int'(lcnt) && int'(idx) < LOG_DEPTH) ?
                               log_rdata : 8'd0;
    rsp_next.queue_empty     = (rp == wp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= CTL_IDLE;
      wp        <= '0;
      rp        <= '0;
      act       <= '0;
      phase     <= PH_REINIT;
      tick      <= '0;
      lcnt      <= '0;
      status    <= ST_PENDING;
      qvalid    <= '0;
      done      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      ctl    <= ctl_next;
      wp     <= wp_next;
      rp     <= rp_next;
      act    <= act_next;
      phase  <= phase_next;
      tick   <= tick_next;
      lcnt   <= lcnt_next;
      status <= status_next;
      qvalid <= qvalid_next;
      done   <= done_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= cmd.log_index;
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

endmodule

### hdl/bmcs_checker.sv
// Port-level checks of the bus master command sequencer, bound to the top level.
`include "assert_macros.svh"

module bmcs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_stall,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input bmcs_pkg::rsp_t               rsp,
  input logic                         pready
);
  import bmcs_pkg::*;

  // a beat in flight blocks the next one
  `CHK_ASSERT(a_busy, (cmd_valid && !cmd_stall) |=> cmd_stall, "no stall after accept")

  // a valid result, this beat's or a held earlier one, follows every accepted beat
  `CHK_ASSERT(a_rsp_follows, (cmd_valid && !cmd_stall) |-> ##3 rsp_valid, "result missing")

  // a finished command always returns the sequencer to fetch
  `CHK_ASSERT(a_done, rsp_valid && rsp.step_done |-> rsp.phase == PH_FETCH, "done off fetch")

  `CHK_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "result moved")

  `CHK_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind bus_master_command_sequencer bmcs_checker u_bmcs_checker (.*);

### verif/bus_master_command_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the bus master command sequencer: directed and random beats.
module bus_master_command_sequencer_tb;
  import bmcs_pkg::*;

  localparam logic [PADDR_W-1:0] LIMIT_ADDR =
    {{(PADDR_W-1){1'b0}}, REG_TIMEOUT_LIMIT} << ADDR_SEL_BIT;
  localparam logic [PADDR_W-1:0] CODE_ADDR =
    {{(PADDR_W-1){1'b0}}, REG_TIMEOUT_CODE} << ADDR_SEL_BIT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] ST_UNUSED   = 2'd3;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd_beat = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_beat;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bus_master_command_sequencer dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd_beat),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted sequencer state
  entry_t            ring [QUEUE_DEPTH];
  logic [QPTR_W-1:0] ring_wr, ring_rd, exec_slot;
  logic [2:0]        seq_phase;
  logic [15:0]       ms_ticks;
  logic [7:0]        err_log [LOG_DEPTH];
  logic [LCNT_W-1:0] err_count;
  status_t           link_st;
  logic [15:0]       limit_ticks;
  logic [7:0]        tmo_code;

  rsp_t expected_reports[$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  function automatic void wipe_ring_and_log();
    for (int i = 0; i < QUEUE_DEPTH; i++) ring[i] = '0;
    for (int i = 0; i < LOG_DEPTH; i++) err_log[i] = '0;
    ring_wr = '0;
    ring_rd = '0;
    err_count = '0;
  endfunction

  function automatic void reset_model();
    wipe_ring_and_log();
    exec_slot = '0;
    seq_phase = PH_REINIT;
    ms_ticks = '0;
    link_st = ST_PENDING;
    limit_ticks = TIMEOUT_LIMIT_RST;
    tmo_code = TIMEOUT_CODE_RST;
  endfunction

  function automatic void fetch_next();
    if (ring_rd != ring_wr) begin
      exec_slot = ring_rd;
      ring_rd = ring_rd + 1'b1;
      seq_phase = PH_EXEC;
    end else begin
      seq_phase = PH_FETCH;
    end
    ms_ticks = '0;
  endfunction

  function automatic void record_error(input logic [7:0] code);
    if (err_count < LOG_DEPTH) begin
      err_log[LIDX_W'(err_count)] = code;
      err_count = err_count + 1'b1;
    end
  endfunction

  function automatic rsp_t advance_sequencer(input cmd_t c);
    rsp_t r;
    logic done;
    logic [1:0] st;
    done = 1'b0;
    case (c.kind)
      KIND_PUSH: begin
        ring[ring_wr].func = c.command_function;
        ring[ring_wr].payload = c.command_payload;
        ring_wr = ring_wr + 1'b1;
      end
      KIND_TICK: begin
        if (ms_ticks != 16'hFFFF) ms_ticks = ms_ticks + 1'b1;
      end
      KIND_POLL: begin
        case (seq_phase)
          PH_REINIT: begin
            wipe_ring_and_log();
            fetch_next();
          end
          PH_FETCH: fetch_next();
          PH_EXEC: begin
            st = c.exec_status;
            if (st > ST_FAIL) st = ST_PENDING;
            link_st = status_t'(st);
            if (st == ST_OK) seq_phase = PH_FINISH;
            if (st == ST_FAIL) seq_phase = PH_SAVE;
            if (ms_ticks > limit_ticks) seq_phase = PH_TIMEOUT;
          end
          PH_TIMEOUT: begin
            link_st = ST_FAIL;
            record_error(tmo_code);
            seq_phase = PH_REINIT;
          end
          PH_SAVE: begin
            record_error(c.error_number);
            seq_phase = PH_FETCH;
            done = 1'b1;
          end
          PH_FINISH: begin
            seq_phase = PH_FETCH;
            done = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.step_done = done;
    r.phase = seq_phase;
    r.active_function = ring[exec_slot].func;
    r.active_payload = ring[exec_slot].payload;
    r.link_status = link_st;
    r.error_count = err_count;
    r.log_entry = (c.log_index < err_count && c.log_index < LOG_DEPTH) ?
                  err_log[c.log_index] : 8'h00;
    r.queue_empty = (ring_rd == ring_wr);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) expected_reports.push_back(advance_sequencer(cmd_beat));
      if (rsp_valid && !rsp_stall) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual %0h", $time, rsp_beat);
        end else begin
          want = expected_reports.pop_front();
          compare_field("step_done", 32'(want.step_done), 32'(rsp_beat.step_done));
          compare_field("phase", 32'(want.phase), 32'(rsp_beat.phase));
          compare_field("active_function", 32'(want.active_function),
                        32'(rsp_beat.active_function));
          compare_field("active_payload", 32'(want.active_payload),
                        32'(rsp_beat.active_payload));
          compare_field("link_status", 32'(want.link_status), 32'(rsp_beat.link_status));
          compare_field("error_count", 32'(want.error_count), 32'(rsp_beat.error_count));
          compare_field("log_entry", 32'(want.log_entry), 32'(rsp_beat.log_entry));
          compare_field("queue_empty", 32'(want.queue_empty), 32'(rsp_beat.queue_empty));
        end
      end
    end
  end

  // result stall: random, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_beat(input cmd_t c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_beat <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    items_sent++;
  endtask

  function automatic cmd_t noise_beat();
    cmd_t c;
    c.kind = 2'($urandom_range(3));
    c.command_function = 5'($urandom_range(31));
    c.command_payload = $urandom;
    c.exec_status = 2'($urandom_range(3));
    c.error_number = 8'($urandom_range(255));
    c.log_index = 4'($urandom_range(15));
    return c;
  endfunction

  task automatic push_cmd(input logic [4:0] func, input logic [31:0] payload);
    cmd_t c;
    c = noise_beat();
    c.kind = KIND_PUSH;
    c.command_function = func;
    c.command_payload = payload;
    send_beat(c);
  endtask

  task automatic tick_ms();
    cmd_t c;
    c = noise_beat();
    c.kind = KIND_TICK;
    send_beat(c);
  endtask

  task automatic poll_seq(input logic [1:0] status, input logic [7:0] errnum);
    cmd_t c;
    c = noise_beat();
    c.kind = KIND_POLL;
    c.exec_status = status;
    c.error_number = errnum;
    send_beat(c);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeouts(input logic [15:0] limit, input logic [7:0] code);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    reg_access(1'b1, LIMIT_ADDR, PDATA_W'(limit), rd);
    reg_access(1'b1, CODE_ADDR, PDATA_W'(code), rd);
    limit_ticks = limit;
    tmo_code = code;
    reg_access(1'b0, LIMIT_ADDR, '0, rd);
    compare_field("timeout_limit readback", 32'(limit), 32'(rd[15:0]));
    reg_access(1'b0, CODE_ADDR, '0, rd);
    compare_field("timeout_code readback", 32'(code), 32'(rd[7:0]));
  endtask

  task automatic test_directed_flow();
    cmd_t c;
    poll_seq(ST_PENDING, 8'h00);        // reinit, then fetch on empty queue
    c = noise_beat();
    c.kind = KIND_UNUSED;
    send_beat(c);
    push_cmd(5'h1F, 32'hFFFF_FFFF);
    push_cmd(5'h00, 32'h0000_0000);
    poll_seq(ST_PENDING, 8'h00);        // fetch -> execute
    poll_seq(ST_PENDING, 8'h00);
    poll_seq(ST_UNUSED, 8'hFF);         // reads as pending
    tick_ms();
    poll_seq(ST_OK, 8'h00);
    poll_seq(ST_PENDING, 8'h00);        // finish
    poll_seq(ST_PENDING, 8'h00);
    poll_seq(ST_FAIL, 8'hFF);
    poll_seq(ST_FAIL, 8'hFF);           // save logs the error number
    poll_seq(ST_PENDING, 8'h00);        // empty fetch holds
    push_cmd(5'd24, 32'h1234_5678);
    wait_idle();
  endtask

  task automatic test_timeout_limits();
    set_timeouts(16'h0000, 8'hFF);
    push_cmd(5'h0A, 32'hA5A5_5A5A);
    poll_seq(ST_PENDING, 8'h00);
    tick_ms();
    poll_seq(ST_OK, 8'h00);             // timeout wins over success
    poll_seq(ST_PENDING, 8'h00);        // logs timeout code
    poll_seq(ST_PENDING, 8'h00);        // reinit wipes the queue and log
    set_timeouts(16'hFFFF, 8'h00);
    push_cmd(5'h15, 32'h0F0F_F0F0);
    poll_seq(ST_PENDING, 8'h00);
    repeat (5) tick_ms();
    poll_seq(ST_PENDING, 8'h00);
    poll_seq(ST_OK, 8'h00);
    poll_seq(ST_PENDING, 8'h00);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [15:0] limit, input logic [7:0] code,
                                     input int count);
    int stop_at, pick, reps, k;
    set_timeouts(limit, code);
    send_idle_pct = idle;
    stall_pct = stall;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // one command through fetch, execute and finish or save
        if ($urandom_range(3) != 0) push_cmd(5'($urandom_range(31)), $urandom);
        poll_seq(ST_PENDING, 8'($urandom));
        reps = ($urandom_range(7) == 0 && limit < 16) ? limit + 1 : $urandom_range(2);
        for (k = 0; k < reps; k++) tick_ms();
        reps = $urandom_range(2);
        for (k = 0; k < reps; k++) poll_seq(ST_PENDING, 8'($urandom));
        poll_seq($urandom_range(1) ? ST_OK : ST_FAIL, 8'($urandom));
        poll_seq(ST_PENDING, 8'($urandom));
      end else if (pick < 65) begin
        reps = $urandom_range(1, 18);
        for (k = 0; k < reps; k++) push_cmd(5'($urandom_range(31)), $urandom);
      end else if (pick < 80) begin
        send_beat(noise_beat());
      end else if (pick < 90) begin
        reps = $urandom_range(1, 5);
        for (k = 0; k < reps; k++) tick_ms();
      end else begin
        reps = $urandom_range(1, 3);
        for (k = 0; k < reps; k++) poll_seq(2'($urandom_range(3)), 8'($urandom));
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 200;
    for (k = 0; k < 120; k++) send_beat(noise_beat());
    wait_idle();
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_flow();
    test_timeout_limits();
    test_random_traffic(0, 0, 16'hFFFF, 8'h5A, 300);
    test_random_traffic(61, 0, 16'd3, 8'hC3, 300);
    test_random_traffic(0, 61, 16'd500, 8'h01, 300);
    test_random_traffic(38, 38, 16'd1, 8'h80, 300);
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("bus_master_command_sequencer verification clean");
    end else begin
      $display("bus_master_command_sequencer verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("bus_master_command_sequencer verification failed");
    $finish;
  end

endmodule
